[hdl/frd_pkg.sv]
// Package for the Faraday rotation derotator: widths, CORDIC constants and
// the arctangent table. No dependencies.
package frd_pkg;

  localparam int unsigned PixelBitsDef = 24;
  localparam int unsigned AngleBitsDef = 20;
  localparam int unsigned CordicSteps  = 30;

  localparam logic [31:0] InvGainQ30 = 32'd652032874;
  localparam logic [63:0] InvPiQ64   = 64'h517CC1B727220A95;

  function automatic logic signed [33:0] atan_turn(input int unsigned idx);
    logic signed [33:0] r;
    case (idx)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
      24: r = 34'sd41;        25: r = 34'sd20;        26: r = 34'sd10;
      27: r = 34'sd5;         28: r = 34'sd3;         29: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/frd_stream_if.sv]
// Valid/ready stream interface carrying one pixel item.
// Depends on nothing; width set by parameter.
interface frd_stream_if #(
  parameter int unsigned PixelBits = 24
);
  logic                        valid;
  logic                        ready;
  logic signed [PixelBits-1:0] q;
  logic signed [PixelBits-1:0] u;
  logic signed [31:0]          rm;
  logic                        last;

  modport source (output valid, q, u, rm, last, input ready);
  modport sink   (input valid, q, u, rm, last, output ready);
endinterface

[hdl/faraday_rotation_derotator.sv]
// Faraday rotation derotator top level: phase pipeline, CORDIC, rotation.
// Depends on frd_pkg, frd_stream_if and frd_cordic_stage.
//
// One pixel enters per clock while the pipeline advances. It has 6 phase
// and rotation stages plus 30 CORDIC stages, 36 in all. The depth is set
// by the 30-stage CORDIC. The whole pipeline advances when the output
// register is empty or being taken, so stalls hold every stage.
// lambda_sq must be written via lambda_we_i/lambda_wdata_i while idle (unchecked).
module faraday_rotation_derotator
  import frd_pkg::*;
#(
  parameter int unsigned PixelBits = frd_pkg::PixelBitsDef,
  parameter int unsigned AngleBits = frd_pkg::AngleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        lambda_we_i,
  input  logic [31:0] lambda_wdata_i,
  frd_stream_if.sink   in_i,
  frd_stream_if.source out_o
);
  localparam int unsigned Depth = CordicSteps + 6;

  logic [31:0] lambda_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lambda_q <= '0;
    else if (lambda_we_i) lambda_q <= lambda_wdata_i;
  end

  logic [Depth-1:0] vld_q;
  logic             adv;
  assign adv      = !vld_q[Depth-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-2:0], in_i.valid};
  end

  // Side data travelling along the whole pipe.
  typedef struct packed {
    logic signed [PixelBits-1:0] q;
    logic signed [PixelBits-1:0] u;
    logic                        blank;
    logic                        last;
    logic                        neg;
  } side_t;
  side_t side_q [Depth-1];

  side_t side_in;
  logic [31:0] mag_in;
  always_comb begin
    side_in.q     = in_i.q;
    side_in.u     = in_i.u;
    side_in.last  = in_i.last;
    side_in.neg   = in_i.rm[31];
    side_in.blank = (in_i.q == {1'b1, {(PixelBits-1){1'b0}}}) ||
                    (in_i.u == {1'b1, {(PixelBits-1){1'b0}}}) ||
                    (in_i.rm == 32'h8000_0000);
    mag_in = in_i.rm[31] ? 32'(-in_i.rm) : in_i.rm;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int i = 1; i < Depth - 1; i++) side_q[i] <= side_q[i-1];
    end
  end

  // Stage 1: P = |rm| * lambda_sq.
  logic [63:0] p_q;
  logic [31:0] mag_q;
  always_ff @(posedge clk_i) if (adv) mag_q <= mag_in;
  always_ff @(posedge clk_i) if (adv) p_q <= 64'(mag_q) * 64'(lambda_q);

  // Stage 2: four 32x32 partial products of P * round(2^64/pi).
  logic [63:0] pp00_q, pp01_q, pp10_q, pp11_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp00_q <= 64'(p_q[31:0])  * 64'(InvPiQ64[31:0]);
      pp01_q <= 64'(p_q[31:0])  * 64'(InvPiQ64[63:32]);
      pp10_q <= 64'(p_q[63:32]) * 64'(InvPiQ64[31:0]);
      pp11_q <= 64'(p_q[63:32]) * 64'(InvPiQ64[63:32]);
    end
  end

  // Stage 3: sum the partials, keep turn bits 44..107 window, round, sign.
  logic [127:0] prod;
  logic [63:0]  field;
  logic [AngleBits-1:0] amag, phase_d, phase_q;
  always_comb begin
    prod  = {64'd0, pp00_q} + {32'd0, pp01_q, 32'd0} + {32'd0, pp10_q, 32'd0} +
            {pp11_q, 64'd0};
    field = prod[107:44];
    amag  = AngleBits'(({1'b0, field[63:63-AngleBits]} + 65'd1) >> 1);
    // Timing of side data: side_q[2] matches this stage's input.
    phase_d = side_q[2].neg ? amag : AngleBits'(-amag);
  end
  always_ff @(posedge clk_i) if (adv) phase_q <= phase_d;

  // CORDIC input, with the quadrant carried alongside.
  logic signed [33:0] cx [CordicSteps+1];
  logic signed [33:0] cy [CordicSteps+1];
  logic signed [33:0] cz [CordicSteps+1];
  logic [1:0]         quad_q [CordicSteps];
  assign cx[0] = 34'(InvGainQ30);
  assign cy[0] = '0;
  assign cz[0] = 34'({phase_q[AngleBits-3:0], {(34-AngleBits){1'b0}}} >> 2);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      quad_q[0] <= phase_q[AngleBits-1:AngleBits-2];
      for (int i = 1; i < CordicSteps; i++) quad_q[i] <= quad_q[i-1];
    end
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
    frd_cordic_stage #(.Step(g)) u_stage (
      .clk_i, .en_i(adv),
      .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]),
      .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1])
    );
  end

  // Quadrant map, then the four products.
  logic signed [33:0] c_m, s_m;
  always_comb begin
    case (quad_q[CordicSteps-1])
      2'd1:    begin c_m = -cy[CordicSteps]; s_m = cx[CordicSteps];  end
      2'd2:    begin c_m = -cx[CordicSteps]; s_m = -cy[CordicSteps]; end
      2'd3:    begin c_m = cy[CordicSteps];  s_m = -cx[CordicSteps]; end
      default: begin c_m = cx[CordicSteps];  s_m = cy[CordicSteps];  end
    endcase
  end

  localparam int unsigned SI = CordicSteps + 3;
  localparam int unsigned PW = PixelBits + 34;
  logic signed [PW-1:0] qc_q, us_q, qs_q, uc_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      qc_q <= PW'(side_q[SI].q) * PW'(c_m);
      us_q <= PW'(side_q[SI].u) * PW'(s_m);
      qs_q <= PW'(side_q[SI].q) * PW'(s_m);
      uc_q <= PW'(side_q[SI].u) * PW'(c_m);
    end
  end

  // Sum, round half up, saturate.
  localparam logic signed [PW:0] Lim = (PW+1)'((64'd1 << (PixelBits - 1)) - 64'd1);
  function automatic logic signed [PixelBits-1:0] rsat(input logic signed [PW:0] a);
    logic signed [PW:0] r;
    r = (a + $signed((PW+1)'(64'd1 << 29))) >>> 30;
    if (r > Lim) r = Lim;
    if (r < -Lim) r = -Lim;
    return PixelBits'(r);
  endfunction

  logic signed [PixelBits-1:0] qo_q, uo_q;
  logic                        lo_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo_q <= side_q[SI+1].last;
      if (side_q[SI+1].blank) begin
        qo_q <= {1'b1, {(PixelBits-1){1'b0}}};
        uo_q <= {1'b1, {(PixelBits-1){1'b0}}};
      end else begin
        qo_q <= rsat((PW+1)'(qc_q) - (PW+1)'(us_q));
        uo_q <= rsat((PW+1)'(qs_q) + (PW+1)'(uc_q));
      end
    end
  end

  assign out_o.valid = vld_q[Depth-1];
  assign out_o.q     = qo_q;
  assign out_o.u     = uo_q;
  assign out_o.last  = lo_q;
  assign out_o.rm    = '0;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.q))
    else $error("output changed while stalled");
  // A computed result saturates short of the blank code, so blank comes in pairs.
  a_blank_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.q == {1'b1, {(PixelBits-1){1'b0}}} |->
      out_o.u == {1'b1, {(PixelBits-1){1'b0}}})
    else $error("blank code on only one output");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("pipeline stalled with empty output");
endmodule

[hdl/frd_cordic_stage.sv]
// One rotation-mode CORDIC iteration, registered, with stall enable.
// Depends on frd_pkg.
module frd_cordic_stage #(
  parameter int unsigned Step = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [33:0]  x_i,
  input  logic signed [33:0]  y_i,
  input  logic signed [33:0]  z_i,
  output logic signed [33:0]  x_o,
  output logic signed [33:0]  y_o,
  output logic signed [33:0]  z_o
);
  import frd_pkg::*;
  logic signed [33:0] x_d, y_d, z_d, x_q, y_q, z_q;

  always_comb begin
    if (!z_i[33]) begin
      x_d = x_i - (y_i >>> Step);
      y_d = y_i + (x_i >>> Step);
      z_d = z_i - atan_turn(Step);
    end else begin
      x_d = x_i + (y_i >>> Step);
      y_d = y_i - (x_i >>> Step);
      z_d = z_i + atan_turn(Step);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule
